[src/ps2mpt_pkg.sv]
// ----------------------------------------------------------------------------
// ps2mpt_pkg
// Types and constants shared by the mouse packet tracker modules.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CURSOR_BITS    = 12;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [CSR_DATA_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd320;
   localparam logic [CSR_DATA_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd200;

   localparam int POS_X_RESET = 160;
   localparam int POS_Y_RESET = 100;

   localparam logic OP_DATA    = 1'b0;
   localparam logic OP_CONSUME = 1'b1;

   localparam logic [7:0] BYTE_SELF_TEST = 8'hAA;
   localparam logic [7:0] BYTE_DEVICE_ID = 8'h00;
   localparam logic [7:0] BYTE_ACK       = 8'hFA;

   localparam int HDR_SYNC_BIT = 3;
   localparam int BTN_LEFT     = 0;
   localparam int BTN_RIGHT    = 1;
   localparam int BTN_MIDDLE   = 2;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_CONSUME,
      CMD_REINIT,
      CMD_SYNC_ERR,
      CMD_EVENT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   delta_x;
      logic [8:0]   delta_y;
      logic [2:0]   buttons;
   } cmd_type;

   typedef struct packed {
      logic                   event_valid;
      logic [7:0]             delta_x;
      logic [8:0]             delta_y;
      logic                   button_left;
      logic                   button_right;
      logic                   button_middle;
      logic [CURSOR_BITS-1:0] cursor_x;
      logic [CURSOR_BITS-1:0] cursor_y;
      logic                   click_pending;
      logic                   click_taken;
      logic                   reinit_request;
      logic                   sync_error;
   } rsp_type;

endpackage

[src/ps2mpt_fifo.sv]
// ----------------------------------------------------------------------------
// ps2mpt_fifo
// Small register queue with show-ahead read; a push is taken while full if
// a pop happens in the same cycle.
// ----------------------------------------------------------------------------
module ps2mpt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = slot_ff[rd_ptr_ff];
   assign do_pop  = pop & ~empty;
   assign do_push = push & (~full | do_pop);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[src/ps2mpt_front.sv]
// ----------------------------------------------------------------------------
// ps2mpt_front
// Packet assembly: classifies each word and builds one command for the back
// end, tracking the byte position within the current packet.
// ----------------------------------------------------------------------------
module ps2mpt_front import ps2mpt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       op,
   input  logic [7:0] data_byte,
   output cmd_type    cmd
);

   logic [1:0] byte_count_ff, byte_count_in;
   logic [7:0] header_byte_ff, header_byte_in;
   logic [7:0] x_move_byte_ff, x_move_byte_in;

   always_comb begin
      byte_count_in  = byte_count_ff;
      header_byte_in = header_byte_ff;
      x_move_byte_in = x_move_byte_ff;
      cmd.kind       = CMD_NONE;
      cmd.delta_x    = x_move_byte_ff;
      cmd.delta_y    = 9'd0 - {data_byte[7], data_byte};
      cmd.buttons    = header_byte_ff[2:0];
      priority if (op == OP_CONSUME) begin
         cmd.kind = CMD_CONSUME;
      end else if (data_byte == BYTE_SELF_TEST) begin
         byte_count_in = 2'd0;
      end else if (data_byte == BYTE_DEVICE_ID && byte_count_ff == 2'd0) begin
         cmd.kind = CMD_REINIT;
      end else if (data_byte == BYTE_ACK) begin
         cmd.kind = CMD_NONE;
      end else if (byte_count_ff == 2'd0) begin
         header_byte_in = data_byte;
         byte_count_in  = 2'd1;
      end else if (byte_count_ff == 2'd1) begin
         x_move_byte_in = data_byte;
         byte_count_in  = 2'd2;
      end else begin
         byte_count_in = 2'd0;
         cmd.kind      = header_byte_ff[HDR_SYNC_BIT] ? CMD_EVENT : CMD_SYNC_ERR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 2'd0;
      end else if (accept) begin
         byte_count_ff <= byte_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         header_byte_ff <= header_byte_in;
         x_move_byte_ff <= x_move_byte_in;
      end
   end

endmodule

[src/ps2mpt_back.sv]
// ----------------------------------------------------------------------------
// ps2mpt_back
// Command execution: holds buttons, pending click, cursor and screen limits,
// and forms the result word for each command.
// ----------------------------------------------------------------------------
module ps2mpt_back import ps2mpt_pkg::*; #(
   parameter int POS_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  cmd_type                   cmd,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output rsp_type                   rsp
);

   localparam int LW = (POS_BITS + 1 > CSR_DATA_BITS) ? POS_BITS + 1 : CSR_DATA_BITS;
   localparam int VW = ((POS_BITS > 9) ? POS_BITS : 9) + 2;

   function automatic logic [POS_BITS-1:0] axis_max(input logic [CSR_DATA_BITS-1:0] lim);
      logic [LW-1:0] lim_ext;
      lim_ext = LW'(lim);
      if (lim_ext == '0) begin
         return '0;
      end else if (lim_ext > (LW'(1) << POS_BITS)) begin
         return '1;
      end else begin
         return POS_BITS'(lim_ext - LW'(1));
      end
   endfunction

   function automatic logic [POS_BITS-1:0] clamp_axis(input logic [POS_BITS-1:0] pos,
                                                      input logic signed [8:0] d,
                                                      input logic [POS_BITS-1:0] hi);
      logic signed [VW-1:0] sum;
      sum = $signed({{(VW - POS_BITS){1'b0}}, pos}) + VW'(d);
      if (sum < 0) begin
         return '0;
      end else if (sum > $signed({{(VW - POS_BITS){1'b0}}, hi})) begin
         return hi;
      end else begin
         return sum[POS_BITS-1:0];
      end
   endfunction

   function automatic logic [CURSOR_BITS-1:0] to_cursor(input logic [POS_BITS-1:0] p);
      logic [31:0] wide;
      wide = 32'(p);
      return wide[CURSOR_BITS-1:0];
   endfunction

   logic [CSR_DATA_BITS-1:0] screen_width_ff;
   logic [CSR_DATA_BITS-1:0] screen_height_ff;
   logic [POS_BITS-1:0]      pos_x_ff, pos_x_in;
   logic [POS_BITS-1:0]      pos_y_ff, pos_y_in;
   logic [2:0]               held_ff, held_in;
   logic                     click_ff, click_in;
   logic [POS_BITS-1:0]      max_x;
   logic [POS_BITS-1:0]      max_y;
   logic                     is_event;

   assign max_x    = axis_max(screen_width_ff);
   assign max_y    = axis_max(screen_height_ff);
   assign is_event = (cmd.kind == CMD_EVENT);

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      held_in  = held_ff;
      click_in = click_ff;
      unique case (cmd.kind)
         CMD_CONSUME: begin
            click_in = 1'b0;
         end
         CMD_EVENT: begin
            if (cmd.buttons[BTN_LEFT] && !held_ff[BTN_LEFT]) begin
               click_in = 1'b1;
            end
            held_in  = cmd.buttons;
            pos_x_in = clamp_axis(pos_x_ff, {cmd.delta_x[7], cmd.delta_x}, max_x);
            pos_y_in = clamp_axis(pos_y_ff, cmd.delta_y, max_y);
         end
         default: begin
            held_in = held_ff;
         end
      endcase
   end

   always_comb begin
      rsp.event_valid    = is_event;
      rsp.delta_x        = is_event ? cmd.delta_x : 8'd0;
      rsp.delta_y        = is_event ? cmd.delta_y : 9'd0;
      rsp.button_left    = held_in[BTN_LEFT];
      rsp.button_right   = held_in[BTN_RIGHT];
      rsp.button_middle  = held_in[BTN_MIDDLE];
      rsp.cursor_x       = to_cursor(pos_x_in);
      rsp.cursor_y       = to_cursor(pos_y_in);
      rsp.click_pending  = click_in;
      rsp.click_taken    = (cmd.kind == CMD_CONSUME) & click_ff;
      rsp.reinit_request = (cmd.kind == CMD_REINIT);
      rsp.sync_error     = (cmd.kind == CMD_SYNC_ERR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= POS_BITS'(POS_X_RESET);
         pos_y_ff <= POS_BITS'(POS_Y_RESET);
         held_ff  <= 3'd0;
         click_ff <= 1'b0;
      end else if (fire) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         held_ff  <= held_in;
         click_ff <= click_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
            default:           screen_width_ff  <= screen_width_ff;
         endcase
      end
   end

   a_consume_clears: assert property (@(posedge clock) disable iff (reset)
      fire && cmd.kind == CMD_CONSUME |=> !click_ff)
      else $error("pending click survived a consume");

   a_event_buttons: assert property (@(posedge clock) disable iff (reset)
      fire && is_event |=> held_ff == $past(cmd.buttons))
      else $error("held buttons not taken from packet header");

   a_cursor_hold: assert property (@(posedge clock) disable iff (reset)
      fire && !is_event |=> $stable(pos_x_ff) && $stable(pos_y_ff))
      else $error("cursor moved without a decoded packet");

endmodule

[src/ps2_mouse_packet_tracker_top.sv]
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_top
// PS/2 mouse three-byte packet decoder with clamped cursor and click latch.
//
//   channel  ports                           handshake
//   req      req_op, req_data_byte           push / full
//   rsp      rsp_* (12 fields)               empty / pop
//   csr      csr_index, csr_wdata            csr_write_en, no wait
//
// One word per cycle sustained while results are popped; every word gives
// exactly one result word. A taken word waits in the command queue, is run
// by the back end as it is written into the result queue, and is then on the
// result ports; a full result queue that is not popped holds it back.
// Reset is synchronous; screen limits return to 320 by 200, cursor to 160,100.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_top import ps2mpt_pkg::*; #(
   parameter int POS_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic                      req_op,
   input  logic [7:0]                req_data_byte,
   output logic                      empty,
   input  logic                      pop,
   output logic                      rsp_event_valid,
   output logic signed [7:0]         rsp_delta_x,
   output logic signed [8:0]         rsp_delta_y,
   output logic                      rsp_button_left,
   output logic                      rsp_button_right,
   output logic                      rsp_button_middle,
   output logic [CURSOR_BITS-1:0]    rsp_cursor_x,
   output logic [CURSOR_BITS-1:0]    rsp_cursor_y,
   output logic                      rsp_click_pending,
   output logic                      rsp_click_taken,
   output logic                      rsp_reinit_request,
   output logic                      rsp_sync_error,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic    accept;
   cmd_type front_cmd;
   cmd_type back_cmd;
   logic    cmd_empty;
   logic    rsp_full;
   logic    fire;
   rsp_type back_rsp;
   rsp_type out_rsp;

   assign accept = push & ~full;
   assign fire   = ~cmd_empty & (~rsp_full | pop);

   ps2mpt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (req_op),
      .data_byte (req_data_byte),
      .cmd       (front_cmd)
   );

   ps2mpt_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .wdata (front_cmd),
      .full  (full),
      .pop   (fire),
      .rdata (back_cmd),
      .empty (cmd_empty)
   );

   ps2mpt_back #(
      .POS_BITS (POS_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .cmd          (back_cmd),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp          (back_rsp)
   );

   ps2mpt_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (fire),
      .wdata (back_rsp),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (out_rsp),
      .empty (empty)
   );

   assign rsp_event_valid    = out_rsp.event_valid;
   assign rsp_delta_x        = out_rsp.delta_x;
   assign rsp_delta_y        = out_rsp.delta_y;
   assign rsp_button_left    = out_rsp.button_left;
   assign rsp_button_right   = out_rsp.button_right;
   assign rsp_button_middle  = out_rsp.button_middle;
   assign rsp_cursor_x       = out_rsp.cursor_x;
   assign rsp_cursor_y       = out_rsp.cursor_y;
   assign rsp_click_pending  = out_rsp.click_pending;
   assign rsp_click_taken    = out_rsp.click_taken;
   assign rsp_reinit_request = out_rsp.reinit_request;
   assign rsp_sync_error     = out_rsp.sync_error;

endmodule
